[rtl/fvg_pkg.sv]
// shared types, constants and codes for the fat volume geometry block
`default_nettype none
package fvg_pkg;

    localparam int unsigned DIV_BITS = 32;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_BPS   = 2'd1;
    localparam logic [1:0] ST_ZERO_SPC  = 2'd2;
    localparam logic [1:0] ST_UNDERFLOW = 2'd3;

    localparam logic [1:0] KIND_FAT12 = 2'd0;
    localparam logic [1:0] KIND_FAT16 = 2'd1;
    localparam logic [1:0] KIND_FAT32 = 2'd2;

    localparam logic [31:0] FAT12_LIMIT  = 32'd4085;
    localparam logic [31:0] FAT16_LIMIT  = 32'd65525;
    localparam logic [15:0] SECTOR_BYTES = 16'd512;

    localparam int unsigned IN_W  = 224;
    localparam int unsigned OUT_W = 128;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  divisor;
        logic [31:0] dstart;
        logic [31:0] fats_end;
        logic [31:0] rprod;
        logic [20:0] dir_bytes;
    } t_side;

endpackage
`default_nettype wire

[rtl/fvg_prep.sv]
// two front stages: field selection, products, sums and error checks
`default_nettype none
module fvg_prep (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [fvg_pkg::IN_W-1:0] i_data,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [31:0]                 o_dividend,
    output fvg_pkg::t_side              o_side
);
    import fvg_pkg::*;

    logic [31:0] w_base, w_fs32, w_ts32, w_rclus;
    logic [15:0] w_resv, w_fs16, w_ts16, w_entries, w_bps;
    logic [7:0]  w_copies, w_spc;

    assign w_base    = i_data[31:0];
    assign w_resv    = i_data[47:32];
    assign w_copies  = i_data[55:48];
    assign w_fs16    = i_data[71:56];
    assign w_fs32    = i_data[103:72];
    assign w_ts16    = i_data[119:104];
    assign w_ts32    = i_data[151:120];
    assign w_entries = i_data[167:152];
    assign w_bps     = i_data[183:168];
    assign w_spc     = i_data[191:184];
    assign w_rclus   = i_data[223:192];

    // stage one
    logic        r_v1;
    logic        w_rdy1;
    logic        w_rdy2;
    logic [31:0] r_base, r_totsec, r_rprod;
    logic [15:0] r_resv;
    logic [39:0] r_fat_area;
    logic [12:0] r_dir_secs;
    logic [7:0]  r_spc;
    logic        r_bps_bad;
    logic [20:0] r_dir_bytes;

    logic [31:0] n_fatsz, n_rclus_m2;
    logic [39:0] n_fat_area;
    logic [39:0] n_rprod_full;

    always_comb begin
        n_fatsz      = (w_fs16 != 16'd0) ? {16'd0, w_fs16} : w_fs32;
        n_rclus_m2   = w_rclus - 32'd2;
        n_fat_area   = {32'd0, w_copies} * {8'd0, n_fatsz};
        n_rprod_full = {8'd0, n_rclus_m2} * {32'd0, w_spc};
    end

    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= i_valid;
        end
        if (i_valid && w_rdy1) begin
            r_base      <= w_base;
            r_resv      <= w_resv;
            r_totsec    <= (w_ts16 != 16'd0) ? {16'd0, w_ts16} : w_ts32;
            r_fat_area  <= n_fat_area;
            r_dir_secs  <= 13'(({1'b0, w_entries} + 17'd15) >> 4);
            r_rprod     <= n_rprod_full[31:0];
            r_spc       <= w_spc;
            r_bps_bad   <= (w_bps != SECTOR_BYTES);
            r_dir_bytes <= {w_entries, 5'd0};
        end
    end

    // stage two
    logic        r_v2;
    logic [40:0] n_overhead;
    logic [31:0] n_fats_end;
    logic [1:0]  n_status;
    logic [31:0] r_dividend;
    t_side       r_side;

    always_comb begin
        n_overhead = {25'd0, r_resv} + {1'b0, r_fat_area} + {28'd0, r_dir_secs};
        n_fats_end = r_base + {16'd0, r_resv} + r_fat_area[31:0];
        if (r_bps_bad) begin
            n_status = ST_BAD_BPS;
        end else if (r_spc == 8'd0) begin
            n_status = ST_ZERO_SPC;
        end else if (n_overhead > {9'd0, r_totsec}) begin
            n_status = ST_UNDERFLOW;
        end else begin
            n_status = ST_OK;
        end
    end

    assign w_rdy2 = !r_v2 || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy2) begin
            r_v2 <= r_v1;
        end
        if (r_v1 && w_rdy2) begin
            r_dividend       <= r_totsec - n_overhead[31:0];
            r_side.status    <= n_status;
            r_side.divisor   <= r_spc;
            r_side.dstart    <= n_fats_end + {19'd0, r_dir_secs};
            r_side.fats_end  <= n_fats_end;
            r_side.rprod     <= r_rprod;
            r_side.dir_bytes <= r_dir_bytes;
        end
    end

    assign o_valid    = r_v2;
    assign o_dividend = r_dividend;
    assign o_side     = r_side;

endmodule
`default_nettype wire

[rtl/fvg_div_cell.sv]
// one restoring divide cell: one quotient bit per cell
`default_nettype none
module fvg_div_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [31:0]    i_word,
    input  wire logic [7:0]     i_rem,
    input  wire fvg_pkg::t_side i_side,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [31:0]         o_word,
    output logic [7:0]          o_rem,
    output fvg_pkg::t_side      o_side
);
    import fvg_pkg::*;

    logic        r_valid;
    logic [31:0] r_word;
    logic [7:0]  r_rem;
    t_side       r_side;
    logic [8:0]  w_part;
    logic [8:0]  w_diff;
    logic        w_fits;

    assign w_part  = {i_rem, i_word[31]};
    assign w_diff  = w_part - {1'b0, i_side.divisor};
    assign w_fits  = (w_part >= {1'b0, i_side.divisor});
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_word <= {i_word[30:0], w_fits};
            r_rem  <= w_fits ? w_diff[7:0] : w_part[7:0];
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
    assign o_rem   = r_rem;
    assign o_side  = r_side;

endmodule
`default_nettype wire

[rtl/fvg_finish.sv]
// type decision, root directory start and output register
`default_nettype none
module fvg_finish (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [31:0]    i_quot,
    input  wire fvg_pkg::t_side i_side,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [fvg_pkg::OUT_W-1:0] o_data
);
    import fvg_pkg::*;

    logic                 r_valid;
    logic [OUT_W-1:0]     r_data;
    logic [1:0]           n_kind;
    logic [31:0]          n_rstart, n_dstart, n_clusters;

    always_comb begin
        if (i_quot < FAT12_LIMIT) begin
            n_kind = KIND_FAT12;
        end else if (i_quot < FAT16_LIMIT) begin
            n_kind = KIND_FAT16;
        end else begin
            n_kind = KIND_FAT32;
        end
        n_rstart   = (n_kind == KIND_FAT32) ? (i_side.rprod + i_side.dstart)
                                            : i_side.fats_end;
        n_dstart   = i_side.dstart;
        n_clusters = i_quot;
        if (i_side.status != ST_OK) begin
            n_kind     = KIND_FAT12;
            n_rstart   = 32'd0;
            n_dstart   = 32'd0;
            n_clusters = 32'd0;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_data <= {7'd0, i_side.dir_bytes, n_clusters, n_rstart, n_dstart,
                       n_kind, i_side.status};
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

[rtl/fat_volume_geometry_top.sv]
// top level of the fat volume geometry block
//
//  channel   dir  tdata bits  content
//  s side    in   224         one boot record with partition base
//  m side    out  128         status, kind, data start, root start, clusters, dir bytes
//
//  one item per cycle enters and leaves while the m side holds tready high
//  (two front stages, 32 divide cells, one output register)
//  the 32-cell divide chain sets the latency, one quotient bit per cell
//  synchronous active-low reset empties every stage
//  each stage holds its item when the next one is full and stalled, so a stall on the
//  m side fills the chain before the s side sees tready low
`default_nettype none
module fat_volume_geometry_top (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_s_tvalid,
    output logic                           o_s_tready,
    // base, reserved, copies, fat size short, fat size long, total short,
    // total long, root entries, bytes per sector, sectors per cluster, root cluster
    input  wire logic [fvg_pkg::IN_W-1:0]  i_s_tdata,
    output logic                           o_m_tvalid,
    input  wire logic                      i_m_tready,
    // status, fat kind, data start, root dir start, cluster count, root dir bytes, pad
    output logic [fvg_pkg::OUT_W-1:0]      o_m_tdata
);
    import fvg_pkg::*;

    logic        w_valid [DIV_BITS+1];
    logic        w_ready [DIV_BITS+1];
    logic [31:0] w_word  [DIV_BITS+1];
    logic [7:0]  w_rem   [DIV_BITS+1];
    t_side       w_side  [DIV_BITS+1];

    fvg_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_data     (i_s_tdata),
        .o_valid    (w_valid[0]),
        .i_ready    (w_ready[0]),
        .o_dividend (w_word[0]),
        .o_side     (w_side[0])
    );

    assign w_rem[0] = 8'd0;

    for (genvar g = 0; g < DIV_BITS; g++) begin : g_cell
        fvg_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_word  (w_word[g]),
            .i_rem   (w_rem[g]),
            .i_side  (w_side[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_word  (w_word[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    fvg_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[DIV_BITS]),
        .o_ready (w_ready[DIV_BITS]),
        .i_quot  (w_word[DIV_BITS]),
        .i_side  (w_side[DIV_BITS]),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata)
    );

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[1:0] != ST_OK) |->
        (o_m_tdata[99:2] == 98'd0))
        else $error("error item carries nonzero geometry");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[3:2] != 2'd3))
        else $error("fat kind out of range");

    a_fat12_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[1:0] == ST_OK && o_m_tdata[3:2] == KIND_FAT12) |->
        (o_m_tdata[99:68] < FAT12_LIMIT))
        else $error("fat12 chosen with large cluster count");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

endmodule
`default_nettype wire
